// ----- rtl/core/szpd_pkg.sv -----
// ----------------------------------------------------------------------------
// szpd_pkg: shared constants of the smoothed z-score peak detector
// Holds the configuration register indexes, the peak flag codes and the
// fixed widths of the configuration fields.
// ----------------------------------------------------------------------------
`default_nettype none

package szpd_pkg;

  // Configuration port
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 9;

  localparam logic [CfgIndexW-1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_Z_THRESHOLD    = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_PEAK_INFLUENCE = 2'd2;

  // Register widths and reset values
  localparam int WinLenW    = 7;
  localparam int ThresholdW = 8;
  localparam int InfluenceW = 9;

  localparam logic [WinLenW-1:0]    WIN_LEN_RESET   = 7'd30;
  localparam logic [ThresholdW-1:0] THRESHOLD_RESET = 8'd80;
  localparam logic [InfluenceW-1:0] INFLUENCE_RESET = 9'd0;
  localparam logic [InfluenceW-1:0] INFLUENCE_ONE   = 9'd256;

  // Peak flag codes
  localparam int FlagW = 2;
  localparam logic [FlagW-1:0] FLAG_NONE = 2'd0;
  localparam logic [FlagW-1:0] FLAG_UP   = 2'd1;
  localparam logic [FlagW-1:0] FLAG_DOWN = 2'd2;

  // Width of squared threshold
  localparam int Thr2W = 2 * ThresholdW;

endpackage

`default_nettype wire

// ----- rtl/core/smoothed_zscore_peak_detector_top.sv -----
// ----------------------------------------------------------------------------
// smoothed_zscore_peak_detector_top: smoothed z-score peak detector
// Flags samples that stand out from the mean of a sliding filtered window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, sample) carries one signed sample per
//   request into a two-entry queue. Each request yields exactly one result
//   request on the output channel (out_valid/out_ready) with peak_flag,
//   window_mean, window_stddev and stats_valid.
//   Configuration: cfg_wen writes cfg_data into register cfg_index
//   (0 window length, 1 threshold, 2 influence) in the same cycle; write
//   only while the block is idle. Writing the window length empties the window.
//   A sample passes the load, spread, threshold product, test, store and
//   update steps; once statistics are valid it also passes the bit-serial
//   square root and the two bit-serial divisions by the window length, which
//   share one divider. One sample is processed at a time, so a new one starts
//   only after the last is done and when the queue is not empty.
//   Reset (rst, synchronous) restores the register defaults and empties the
//   window. When the receiver stalls, the result stays in the output
//   register, the back end finishes the next sample and waits, and the
//   input queue keeps taking requests until it holds two.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothed_zscore_peak_detector_top #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [szpd_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [szpd_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [SAMPLE_BITS-1:0]         sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [szpd_pkg::FlagW-1:0]          peak_flag,
  output logic [SAMPLE_BITS-1:0]              window_mean,
  output logic [SAMPLE_BITS-1:0]              window_stddev,
  output logic                                stats_valid
);

  logic                   q_valid;
  logic [SAMPLE_BITS-1:0] q_sample;
  logic                   q_pop;

  szpd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .q_valid  (q_valid),
    .q_sample (q_sample),
    .q_pop    (q_pop)
  );

  szpd_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_sample      (q_sample),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .peak_flag     (peak_flag),
    .window_mean   (window_mean),
    .window_stddev (window_stddev),
    .stats_valid   (stats_valid)
  );

endmodule

`default_nettype wire

// ----- rtl/core/szpd_front.sv -----
// ----------------------------------------------------------------------------
// szpd_front: input queue
// Two-entry queue that takes sample requests and hands them to the back end,
// so the input side keeps accepting while the back end is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module szpd_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        q_valid,
  output logic [SAMPLE_BITS-1:0]      q_sample,
  input  wire logic                   q_pop
);

  logic [SAMPLE_BITS-1:0] slot [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   push;
  logic                   pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_sample = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= sample;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/szpd_isqrt.sv -----
// ----------------------------------------------------------------------------
// szpd_isqrt: iterative integer square root
// Digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module szpd_isqrt #(
  parameter int OPW = 45
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [OPW-1:0]       operand,
  output logic                      busy,
  output logic [(OPW+1)/2-1:0]      root
);

  localparam int RW   = (OPW + 1) / 2;
  localparam int REMW = RW + 2;
  localparam int CNTW = $clog2(RW + 1);

  logic [2*RW-1:0] opnd;
  logic [REMW-1:0] rem;
  logic [CNTW-1:0] cnt;
  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            fits;

  // One root bit per step
  always_comb begin
    rem_sh = {rem[RW-1:0], opnd[2*RW-1:2*RW-2]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= (2*RW)'(operand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      opnd <= {opnd[2*RW-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[RW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(RW);
    end else if (busy) begin
      cnt <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/szpd_div.sv -----
// ----------------------------------------------------------------------------
// szpd_div: iterative unsigned divider
// Restoring division by the window length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module szpd_div #(
  parameter int NW = 23,
  parameter int DW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               busy,
  output logic [NW-1:0]      quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem;
  logic [DW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     rem_sh;
  logic            fits;
  logic [DW:0]     diff;

  always_comb begin
    rem_sh = {rem, quotient[NW-1]};
    fits   = (rem_sh >= {1'b0, dvs});
    diff   = rem_sh - {1'b0, dvs};
  end

  // Dividend shifts out the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[NW-2:0], fits};
      rem      <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(NW);
    end else if (busy) begin
      cnt <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/szpd_back.sv -----
// ----------------------------------------------------------------------------
// szpd_back: detection and statistics sequencer
// Holds the configuration, the filtered window and its running sums, tests
// each sample, updates the window and computes mean and deviation.
// ----------------------------------------------------------------------------
`default_nettype none

module szpd_back #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wen,
  input  wire logic [szpd_pkg::CfgIndexW-1:0]    cfg_index,
  input  wire logic [szpd_pkg::CfgDataW-1:0]     cfg_data,
  input  wire logic                              q_valid,
  input  wire logic [SAMPLE_BITS-1:0]            q_sample,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [szpd_pkg::FlagW-1:0]             peak_flag,
  output logic [SAMPLE_BITS-1:0]                 window_mean,
  output logic [SAMPLE_BITS-1:0]                 window_stddev,
  output logic                                   stats_valid
);

  localparam int SB   = SAMPLE_BITS;
  localparam int LW   = $clog2(WINDOW_MAX + 1);
  localparam int AW   = $clog2(WINDOW_MAX);
  localparam int SUMW = SB + AW + 1;
  localparam int QW   = 2 * SB + AW;
  localparam int VW   = LW + QW;
  localparam int DW   = SUMW + 1;
  localparam int HW   = VW / 2;
  localparam int RW   = (VW + 1) / 2;
  localparam int NW   = (SUMW > RW) ? SUMW : RW;
  localparam int T2W  = szpd_pkg::Thr2W;
  localparam int CW   = T2W + VW;
  localparam int MW   = SB + szpd_pkg::InfluenceW + 1;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_LOAD   = 13'b0000000000010,
    ST_SPREAD = 13'b0000000000100,
    ST_RHS    = 13'b0000000001000,
    ST_TEST   = 13'b0000000010000,
    ST_STORE  = 13'b0000000100000,
    ST_UPDATE = 13'b0000001000000,
    ST_STATS1 = 13'b0000010000000,
    ST_STATS2 = 13'b0000100000000,
    ST_ROOT   = 13'b0001000000000,
    ST_MEAN   = 13'b0010000000000,
    ST_SD     = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [szpd_pkg::WinLenW-1:0]    reg_window_length;
  logic [szpd_pkg::ThresholdW-1:0] reg_z_threshold;
  logic [szpd_pkg::InfluenceW-1:0] reg_peak_influence;

  // Window state
  logic signed [SB-1:0]   ring [WINDOW_MAX];
  logic signed [SB-1:0]   ring_rd;
  logic [AW-1:0]          write_pointer;
  logic [LW-1:0]          fill_count;
  logic signed [SUMW-1:0] running_sum;
  logic [QW-1:0]          running_square_sum;
  logic signed [SB-1:0]   last_filtered;

  // Datapath registers
  logic signed [SB-1:0]   x;
  logic signed [SB-1:0]   old;
  logic signed [SB-1:0]   stored;
  logic signed [DW-1:0]   d;
  logic [VW-1:0]          lq;
  logic [VW-1:0]          ss;
  logic [VW-1:0]          v;
  logic [T2W-1:0]         thr2;
  logic [2*DW-1:0]        dd;
  logic [T2W+HW-1:0]      rhs_lo;
  logic [T2W+VW-HW-1:0]   rhs_hi;
  logic signed [MW-1:0]   mix;
  logic [2*SB-1:0]        oldsq;
  logic [2*SB-1:0]        sq;
  logic                   full;
  logic                   valid_after;
  logic [szpd_pkg::FlagW-1:0] flag;
  logic                   mean_neg;
  logic [SB-1:0]          mean_r;

  // Combinational helpers
  logic [LW-1:0]                   len;
  logic [szpd_pkg::InfluenceW-1:0] inf;
  logic [AW-1:0]                   rd_addr;
  logic [LW:0]                     addr_tmp;
  logic [LW:0]                     wp_ext;
  logic [LW:0]                     len_ext;
  logic signed [2*SUMW-1:0]        s_sq;
  logic signed [2*DW-1:0]          d_sq;
  logic signed [2*SB-1:0]          old_sq;
  logic signed [2*SB-1:0]          st_sq;
  logic [CW-1:0]                   lhs;
  logic [CW-1:0]                   rhs;
  logic                            peak;
  logic [NW-1:0]                   sum_abs;
  logic [LW:0]                     fill_inc;

  // Arithmetic units
  logic          div_start;
  logic [NW-1:0] div_dividend;
  logic          div_busy;
  logic [NW-1:0] div_q;
  logic          sqrt_start;
  logic          sqrt_busy;
  logic [RW-1:0] sqrt_root;

  // Effective window length and influence
  always_comb begin
    if (reg_window_length < szpd_pkg::WinLenW'(2)) begin
      len = LW'(2);
    end else if (int'(reg_window_length) > WINDOW_MAX) begin
      len = LW'(WINDOW_MAX);
    end else begin
      len = LW'(reg_window_length);
    end
    inf = (reg_peak_influence > szpd_pkg::INFLUENCE_ONE) ?
          szpd_pkg::INFLUENCE_ONE : reg_peak_influence;
  end

  // Address of the entry leaving the window
  always_comb begin
    wp_ext  = (LW+1)'(write_pointer);
    len_ext = (LW+1)'(len);
    if (wp_ext >= len_ext) addr_tmp = wp_ext - len_ext;
    else addr_tmp = wp_ext + (LW+1)'(WINDOW_MAX) - len_ext;
    rd_addr = addr_tmp[AW-1:0];
  end

  // Products and compare
  always_comb begin
    s_sq    = (2*SUMW)'(running_sum) * (2*SUMW)'(running_sum);
    d_sq    = (2*DW)'(d) * (2*DW)'(d);
    old_sq  = (2*SB)'(old) * (2*SB)'(old);
    st_sq   = (2*SB)'(stored) * (2*SB)'(stored);
    lhs     = CW'({dd, 8'b0});
    rhs     = CW'(rhs_lo) + (CW'(rhs_hi) << HW);
    peak    = full && (lhs > rhs);
    sum_abs = running_sum[SUMW-1] ? NW'(-running_sum) : NW'(running_sum);
    fill_inc = (LW+1)'(fill_count) + (LW+1)'(1);
  end

  // Ring memory
  always_ff @(posedge clk) begin
    ring_rd <= ring[rd_addr];
    if (state == ST_STORE) begin
      ring[write_pointer] <= stored;
    end
  end

  // Next state
  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = sum_abs;
    sqrt_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:   state_next = ST_SPREAD;
      ST_SPREAD: state_next = ST_RHS;
      ST_RHS:    state_next = ST_TEST;
      ST_TEST:   state_next = ST_STORE;
      ST_STORE:  state_next = ST_UPDATE;
      ST_UPDATE: begin
        state_next = (full || (fill_inc >= (LW+1)'(len))) ? ST_STATS1 : ST_DONE;
      end
      ST_STATS1: state_next = ST_STATS2;
      ST_STATS2: state_next = ST_ROOT;
      ST_ROOT: begin
        div_start  = 1'b1;
        sqrt_start = 1'b1;
        state_next = ST_MEAN;
      end
      ST_MEAN: begin
        if (!div_busy && !sqrt_busy) begin
          div_start    = 1'b1;
          div_dividend = NW'(sqrt_root);
          state_next   = ST_SD;
        end
      end
      ST_SD: begin
        if (!div_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state, configuration and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      reg_window_length  <= szpd_pkg::WIN_LEN_RESET;
      reg_z_threshold    <= szpd_pkg::THRESHOLD_RESET;
      reg_peak_influence <= szpd_pkg::INFLUENCE_RESET;
      write_pointer      <= '0;
      fill_count         <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      last_filtered      <= '0;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;

      // Result register
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      // Window update
      if (state == ST_STORE) begin
        running_sum <= running_sum + SUMW'(stored) - (full ? SUMW'(old) : SUMW'(0));
      end
      if (state == ST_UPDATE) begin
        running_square_sum <= running_square_sum + QW'(sq) - (full ? QW'(oldsq) : QW'(0));
        write_pointer <= (write_pointer == AW'(WINDOW_MAX - 1)) ? '0 :
                         write_pointer + AW'(1);
        if (!full) fill_count <= fill_count + LW'(1);
        last_filtered <= stored;
      end

      // Register writes; a new window length empties the window
      if (cfg_wen) begin
        case (cfg_index)
          szpd_pkg::REG_WINDOW_LENGTH: begin
            reg_window_length  <= cfg_data[szpd_pkg::WinLenW-1:0];
            write_pointer      <= '0;
            fill_count         <= '0;
            running_sum        <= '0;
            running_square_sum <= '0;
          end
          szpd_pkg::REG_Z_THRESHOLD:
            reg_z_threshold <= cfg_data[szpd_pkg::ThresholdW-1:0];
          szpd_pkg::REG_PEAK_INFLUENCE:
            reg_peak_influence <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x    <= $signed(q_sample);
        full <= (fill_count >= len);
      end
      ST_LOAD: begin
        old  <= ring_rd;
        d    <= DW'(x) * DW'($signed({1'b0, len})) - DW'(running_sum);
        lq   <= VW'(len) * VW'(running_square_sum);
        ss   <= VW'(s_sq);
        thr2 <= T2W'(reg_z_threshold) * T2W'(reg_z_threshold);
      end
      ST_SPREAD: begin
        v  <= lq - ss;
        dd <= d_sq;
      end
      ST_RHS: begin
        rhs_lo <= (T2W+HW)'(thr2) * (T2W+HW)'(v[HW-1:0]);
        rhs_hi <= (T2W+VW-HW)'(thr2) * (T2W+VW-HW)'(v[VW-1:HW]);
        mix    <= MW'($signed({1'b0, inf})) * MW'(x) +
                  MW'($signed({1'b0, szpd_pkg::INFLUENCE_ONE - inf})) * MW'(last_filtered);
      end
      ST_TEST: begin
        stored <= peak ? mix[SB+7:8] : x;
        if (!peak) flag <= szpd_pkg::FLAG_NONE;
        else if (d > 0) flag <= szpd_pkg::FLAG_UP;
        else flag <= szpd_pkg::FLAG_DOWN;
        oldsq <= old_sq;
      end
      ST_STORE: begin
        sq <= st_sq;
      end
      ST_UPDATE: begin
        valid_after <= full || (fill_inc >= (LW+1)'(len));
        mean_r      <= '0;
      end
      ST_STATS1: begin
        lq <= VW'(len) * VW'(running_square_sum);
        ss <= VW'(s_sq);
      end
      ST_STATS2: begin
        v        <= lq - ss;
        mean_neg <= running_sum[SUMW-1];
      end
      ST_MEAN: begin
        if (!div_busy && !sqrt_busy) begin
          mean_r <= mean_neg ? SB'(-div_q) : SB'(div_q);
        end
      end
      default: ;
    endcase
  end

  // Result register load
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      peak_flag     <= flag;
      stats_valid   <= valid_after;
      window_mean   <= valid_after ? mean_r : '0;
      window_stddev <= valid_after ? SB'(div_q) : '0;
    end
  end

  szpd_div #(
    .NW (NW),
    .DW (LW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (len),
    .busy     (div_busy),
    .quotient (div_q)
  );

  szpd_isqrt #(
    .OPW (VW)
  ) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .operand (v),
    .busy    (sqrt_busy),
    .root    (sqrt_root)
  );

endmodule

`default_nettype wire

// ----- tb/szpd_checker.sv -----
// ----------------------------------------------------------------------------
// szpd_checker: result scoreboard for the smoothed z-score peak detector
// Watches the configuration port and both request channels. Every accepted
// sample is run through a local model of the filtered window. Every accepted
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module szpd_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [szpd_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [szpd_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [15:0]                    sample,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [szpd_pkg::FlagW-1:0]     peak_flag,
  input  wire logic [15:0]                    window_mean,
  input  wire logic [15:0]                    window_stddev,
  input  wire logic                           stats_valid,
  output int                                  pending,
  output int                                  errors
);

  typedef struct packed {
    logic [szpd_pkg::FlagW-1:0] flag;
    logic [15:0]                mean;
    logic [15:0]                sdev;
    logic                       full;
  } window_stats_t;

  window_stats_t stats_queue[$];

  // Local copy of the registers and the window
  logic [szpd_pkg::WinLenW-1:0]    win_len_reg;
  logic [szpd_pkg::ThresholdW-1:0] thr_reg;
  logic [szpd_pkg::InfluenceW-1:0] infl_reg;
  longint                          filt_ring[64];
  int                              wr_ptr;
  int                              fill_cnt;
  longint                          sum_acc;
  longint unsigned                 sq_acc;
  longint                          prev_filt;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic int active_len();
    if (win_len_reg < 2) return 2;
    if (win_len_reg > 64) return 64;
    return int'(win_len_reg);
  endfunction

  function automatic longint unsigned window_spread(int len);
    return longint'(len) * sq_acc - longint'(sum_acc) * longint'(sum_acc);
  endfunction

  // Advance the window by one sample and return the predicted result
  function automatic window_stats_t track_sample(logic [15:0] raw);
    window_stats_t   res;
    int              len;
    longint          x;
    longint          dev;
    longint          absdev;
    longint          mix;
    longint          stored;
    longint          old_val;
    longint unsigned lhs;
    longint unsigned rhs;
    longint          infl;
    len = active_len();
    x = longint'($signed(raw));
    stored = x;
    res = '0;
    res.flag = szpd_pkg::FLAG_NONE;
    if (fill_cnt >= len) begin
      dev = x * len - sum_acc;
      absdev = (dev < 0) ? -dev : dev;
      lhs = longint'(absdev) * longint'(absdev) * 256;
      rhs = longint'(thr_reg) * longint'(thr_reg) * window_spread(len);
      if (lhs > rhs) begin
        infl = (infl_reg > szpd_pkg::INFLUENCE_ONE) ? 256 : longint'(infl_reg);
        mix = infl * x + (256 - infl) * prev_filt;
        stored = mix >>> 8;
        res.flag = (dev > 0) ? szpd_pkg::FLAG_UP : szpd_pkg::FLAG_DOWN;
      end
      old_val = filt_ring[(wr_ptr + 64 - len) % 64];
      sum_acc = sum_acc - old_val;
      sq_acc = sq_acc - longint'(old_val * old_val);
    end else begin
      fill_cnt++;
    end
    filt_ring[wr_ptr] = stored;
    wr_ptr = (wr_ptr + 1) % 64;
    sum_acc = sum_acc + stored;
    sq_acc = sq_acc + longint'(stored * stored);
    prev_filt = stored;
    if (fill_cnt >= len) begin
      res.full = 1'b1;
      res.mean = 16'(sum_acc / len);
      res.sdev = 16'(int_sqrt(window_spread(len)) / len);
    end
    return res;
  endfunction

  function automatic void empty_window();
    wr_ptr = 0;
    fill_cnt = 0;
    sum_acc = 0;
    sq_acc = 0;
  endfunction

  assign pending = stats_queue.size();

  always @(posedge clk) begin
    window_stats_t want;
    if (rst) begin
      win_len_reg = szpd_pkg::WIN_LEN_RESET;
      thr_reg = szpd_pkg::THRESHOLD_RESET;
      infl_reg = szpd_pkg::INFLUENCE_RESET;
      empty_window();
      prev_filt = 0;
      stats_queue.delete();
    end else begin
      // Register writes
      if (cfg_wen) begin
        case (cfg_index)
          szpd_pkg::REG_WINDOW_LENGTH: begin
            win_len_reg = cfg_data[szpd_pkg::WinLenW-1:0];
            empty_window();
          end
          szpd_pkg::REG_Z_THRESHOLD:    thr_reg = cfg_data[szpd_pkg::ThresholdW-1:0];
          szpd_pkg::REG_PEAK_INFLUENCE: infl_reg = cfg_data;
          default: ;
        endcase
      end
      // Sample request accepted
      if (in_valid && in_ready) stats_queue.push_back(track_sample(sample));
      // Result request accepted
      if (out_valid && out_ready) begin
        if (stats_queue.size() == 0) begin
          $display("%0t: result with nothing expected: flag %0d mean %h sd %h full %b",
                   $time, peak_flag, window_mean, window_stddev, stats_valid);
          errors++;
        end else begin
          want = stats_queue.pop_front();
          if (peak_flag !== want.flag) begin
            $display("%0t: peak_flag expected %0d actual %0d", $time, want.flag, peak_flag);
            errors++;
          end
          if (window_mean !== want.mean) begin
            $display("%0t: window_mean expected %h actual %h", $time, want.mean, window_mean);
            errors++;
          end
          if (window_stddev !== want.sdev) begin
            $display("%0t: window_stddev expected %h actual %h",
                     $time, want.sdev, window_stddev);
            errors++;
          end
          if (stats_valid !== want.full) begin
            $display("%0t: stats_valid expected %b actual %b", $time, want.full, stats_valid);
            errors++;
          end
        end
      end
    end
  end

  initial errors = 0;

endmodule

// ----- tb/smoothed_zscore_peak_detector_top_test.sv -----
// ----------------------------------------------------------------------------
// smoothed_zscore_peak_detector_top_test: regression for the peak detector
// Drives directed corner samples and random phases of noisy baselines with
// spikes, flat runs and full-range noise under many register settings, with
// bursty input and a stalling receiver. The checker module does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smoothed_zscore_peak_detector_top_test;

  localparam logic [szpd_pkg::CfgIndexW-1:0] REG_SPARE = 2'd3;
  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 80;

  logic                           clk;
  logic                           rst;
  logic                           cfg_wen;
  logic [szpd_pkg::CfgIndexW-1:0] cfg_index;
  logic [szpd_pkg::CfgDataW-1:0]  cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [15:0]                    sample;
  logic                           out_valid;
  logic                           out_ready;
  logic [szpd_pkg::FlagW-1:0]     peak_flag;
  logic [15:0]                    window_mean;
  logic [15:0]                    window_stddev;
  logic                           stats_valid;
  int                             pending;
  int                             errors;
  int                             cycles;
  logic                           hold_request;

  smoothed_zscore_peak_detector_top uut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .sample(sample), .out_valid(out_valid), .out_ready(out_ready),
    .peak_flag(peak_flag), .window_mean(window_mean),
    .window_stddev(window_stddev), .stats_valid(stats_valid)
  );

  szpd_checker scoreboard (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .sample(sample), .out_valid(out_valid), .out_ready(out_ready),
    .peak_flag(peak_flag), .window_mean(window_mean),
    .window_stddev(window_stddev), .stats_valid(stats_valid),
    .pending(pending), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: stall pattern changes every so often, plus one long hold-off
  initial begin
    int mode;
    int span;
    int hold_cnt;
    bit hold_done;
    out_ready = 1'b0;
    hold_done = 0;
    hold_cnt = 0;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1;
        hold_cnt = 600;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 400);
      end
      span--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 0);
          2: out_ready <= ($urandom_range(0, 9) == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send_sample(logic [15:0] v);
    in_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Bursty sender: a random gap after each burst
  int burst_left;
  task automatic offer(logic [15:0] v);
    int gap;
    send_sample(v);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Wait until every result is back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One write per call, with cfg_wen low again before the task returns
  task automatic write_reg(logic [szpd_pkg::CfgIndexW-1:0] idx,
                           logic [szpd_pkg::CfgDataW-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] clip16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  // Noisy baseline, spikes, flat runs and full-range noise
  function automatic logic [15:0] pick_sample(int base, int amp, int flat_val);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return clip16(base + $urandom_range(0, 2 * amp) - amp);
    if (r < 78) return clip16(base + (($urandom_range(0, 1) != 0) ? 1 : -1)
                              * $urandom_range(amp * 3 + 1, 20000));
    if (r < 88) return 16'($urandom);
    return clip16(flat_val);
  endfunction

  task automatic random_phase(int count);
    int base;
    int amp;
    int flat_val;
    int r;
    base = $urandom_range(0, 40000) - 20000;
    amp = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2000);
    flat_val = base;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 29);
      if (r == 0) flat_val = $urandom_range(0, 65535) - 32768;
      offer(pick_sample(base, amp, flat_val));
    end
  endtask

  // Corner samples with a short window and full influence
  task automatic directed_part();
    logic [15:0] corner[$];
    corner = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0000,
               16'h0005, 16'h0005, 16'h0005, 16'h0005, 16'h0006,
               16'hfff0, 16'h0005, 16'h8000, 16'h7fff, 16'hffff,
               16'h0001, 16'h0000, 16'h5555, 16'haaaa, 16'h0000};
    foreach (corner[k]) offer(corner[k]);
  endtask

  initial begin
    int len_pick;
    int phase_items;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_index = szpd_pkg::REG_WINDOW_LENGTH;
    cfg_data = '0;
    in_valid = 1'b0;
    sample = '0;
    hold_request = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first
    random_phase(120);
    settle();

    write_reg(szpd_pkg::REG_WINDOW_LENGTH, 9'd2);
    write_reg(szpd_pkg::REG_Z_THRESHOLD, 9'd16);
    write_reg(szpd_pkg::REG_PEAK_INFLUENCE, szpd_pkg::INFLUENCE_ONE);
    directed_part();
    settle();

    // Zero threshold, oversize influence, window length below the floor
    write_reg(szpd_pkg::REG_WINDOW_LENGTH, 9'd0);
    write_reg(szpd_pkg::REG_Z_THRESHOLD, 9'd0);
    write_reg(szpd_pkg::REG_PEAK_INFLUENCE, 9'd511);
    write_reg(REG_SPARE, 9'h1ff);
    random_phase(60);
    settle();

    write_reg(szpd_pkg::REG_WINDOW_LENGTH, 9'd1);
    write_reg(szpd_pkg::REG_Z_THRESHOLD, 9'd255);
    random_phase(60);
    settle();

    // Longest window; long receiver hold-off while samples keep coming
    write_reg(szpd_pkg::REG_WINDOW_LENGTH, 9'd64);
    write_reg(szpd_pkg::REG_Z_THRESHOLD, 9'd20);
    write_reg(szpd_pkg::REG_PEAK_INFLUENCE, 9'd0);
    hold_request <= 1'b1;
    random_phase(200);
    settle();

    write_reg(szpd_pkg::REG_WINDOW_LENGTH, 9'd127);
    write_reg(szpd_pkg::REG_Z_THRESHOLD, 9'd40);
    write_reg(szpd_pkg::REG_PEAK_INFLUENCE, 9'd128);
    random_phase(150);
    settle();

    // Same length written again still empties the window
    write_reg(szpd_pkg::REG_WINDOW_LENGTH, 9'd127);
    random_phase(80);
    settle();

    // Random settings, mostly short windows
    for (int p = 0; p < 10; p++) begin
      len_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                             : $urandom_range(2, 16);
      write_reg(szpd_pkg::REG_WINDOW_LENGTH, 9'(len_pick));
      write_reg(szpd_pkg::REG_Z_THRESHOLD, 9'($urandom_range(0, 255)));
      write_reg(szpd_pkg::REG_PEAK_INFLUENCE, 9'($urandom_range(0, 511)));
      phase_items = $urandom_range(100, 140);
      random_phase(phase_items);
      settle();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
